>>> sv/estc_pkg.sv
// estc_pkg: shared types, pipeline latencies and reciprocal constants
// for the epoch seconds to utc calendar converter
// no dependencies
package estc_pkg;

  // pipeline depth of each section, in clock cycles
  localparam int unsigned DAY_LAT   = 3;
  localparam int unsigned DATE_LAT  = 8;
  localparam int unsigned TOD_LAT   = 4;
  localparam int unsigned TOTAL_LAT = DAY_LAT + DATE_LAT;

  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  // days from march 1 of year 0 to 1970-01-01
  localparam logic [19:0] DAYS_FROM_MAR0 = 20'(719527 - 31 - 28);
  localparam logic [17:0] DAYS_PER_400Y  = 18'(365 * 400 + 100 - 4 + 1);
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [8:0]  FIRST_JAN_YDAY = 9'd306;

  // floor reciprocals, estimate low by at most one
  localparam int unsigned    DAY_SHIFT  = 35;
  localparam logic [25:0]    RECIP_DAY  = 26'((64'd1 << DAY_SHIFT) / 675);
  localparam int unsigned    YEAR_SHIFT = 24;
  localparam logic [15:0]    RECIP_YEAR = 16'((64'd400 << YEAR_SHIFT) / 146097);

  // ceiling reciprocals, exact over the value ranges in use
  localparam logic [12:0] RECIP_100 = 13'(((64'd1 << 19) + 99) / 100);
  localparam logic [16:0] RECIP_7   = 17'(((64'd1 << 19) + 6) / 7);
  localparam logic [13:0] RECIP_225 = 14'(((64'd1 << 21) + 224) / 225);
  localparam logic [10:0] RECIP_15  = 11'(((64'd1 << 14) + 14) / 15);
  localparam logic [11:0] RECIP_153 = 12'(((64'd1 << 19) + 152) / 153);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
  } cal_date_t;

  // days before each month of a march-based year, 367 * mon / 12 - 30
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd61;
      4'd4:    d = 9'd92;
      4'd5:    d = 9'd122;
      4'd6:    d = 9'd153;
      4'd7:    d = 9'd184;
      4'd8:    d = 9'd214;
      4'd9:    d = 9'd245;
      4'd10:   d = 9'd275;
      4'd11:   d = 9'd306;
      4'd12:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> sv/estc_time_of_day.sv
// estc_time_of_day: four-stage split of seconds within a day into
// hour, minute and second; depends on estc_pkg
module estc_time_of_day
  import estc_pkg::*;
(
  input  logic        clk,
  input  logic [16:0] secs_of_day,
  output tod_t        tod
);

  logic [25:0] hp1;
  logic [16:0] r1;
  logic [4:0]  hr2;
  logic [11:0] r2;
  logic [19:0] mp3;
  logic [11:0] r3;
  logic [4:0]  hr3;

  logic [4:0]  hr_est;
  logic [16:0] r_min;
  logic [5:0]  mn_est;
  logic [11:0] s_diff;

  always_comb begin
    hr_est = hp1[25:21];
    r_min  = r1 - 17'(hr_est) * 17'(SECS_PER_HOUR);
    mn_est = mp3[19:14];
    s_diff = r3 - 12'(mn_est) * 12'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    hp1        <= 26'(secs_of_day[16:4]) * 26'(RECIP_225);
    r1         <= secs_of_day;
    hr2        <= hr_est;
    r2         <= r_min[11:0];
    mp3        <= 20'(r2[11:2]) * 20'(RECIP_15);
    r3         <= r2;
    hr3        <= hr2;
    tod.hour   <= hr3;
    tod.minute <= mn_est;
    tod.second <= s_diff[5:0];
  end

endmodule

>>> sv/estc_civil_date.sv
// estc_civil_date: eight-stage conversion of days since 1970-01-01 into
// year, month, day of month and weekday; depends on estc_pkg
module estc_civil_date
  import estc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] days,
  output logic        out_valid,
  output cal_date_t   date
);

  logic [DATE_LAT-1:0] valid;

  // stage 1
  logic [19:0] d1;
  logic [35:0] py1;
  logic [15:0] dw1;
  logic [32:0] pw1;
  // stage 2
  logic [19:0] d2;
  logic [11:0] y2;
  logic [18:0] r2;
  logic [2:0]  wd2;
  // stage 3
  logic [19:0] d3;
  logic [11:0] y3;
  logic [2:0]  wd3;
  // stage 4
  logic [19:0] d4;
  logic [11:0] y4;
  logic [4:0]  q4;
  logic [2:0]  wd4;
  // stage 5
  logic [19:0] d5;
  logic [11:0] y5;
  logic [19:0] dby5;
  logic        leap5;
  logic [2:0]  wd5;
  // stage 6
  logic [8:0]  yday6;
  logic [11:0] y6;
  logic [2:0]  wd6;
  // stage 7
  logic [8:0]  yday7;
  logic [11:0] y7;
  logic [3:0]  mon7;
  logic [2:0]  wd7;

  logic [19:0] d_shift;
  logic [15:0] dw_next;
  logic [11:0] y_est;
  logic [28:0] x_scaled;
  logic [28:0] r_full;
  logic [13:0] q7;
  logic [15:0] wd_full;
  logic [23:0] p100;
  logic [19:0] dby_next;
  logic [11:0] c100;
  logic        leap_next;
  logic [20:0] yd_diff;
  logic [10:0] m_arg;
  logic [10:0] m_arg5;
  logic [22:0] mp;
  logic [8:0]  mday;
  logic        late;

  always_comb begin
    d_shift   = 20'(days) + DAYS_FROM_MAR0;
    dw_next   = days + 16'd4;
    y_est     = py1[35:24];
    x_scaled  = 29'(d1 + 20'd2) * 29'd400;
    r_full    = x_scaled - 29'(y_est) * 29'(DAYS_PER_400Y);
    q7        = pw1[32:19];
    wd_full   = dw1 - 16'(q7) * 16'd7;
    p100      = 24'(y3) * 24'(RECIP_100);
    dby_next  = 20'(y4) * 20'(DAYS_PER_YEAR) + 20'(y4[11:2]) - 20'(q4) + 20'(q4[4:2]);
    c100      = 12'(q4) * 12'd100;
    leap_next = (y4[1:0] == 2'd0) && ((y4 != c100) || (q4[1:0] == 2'd0));
    yd_diff   = 21'(d5) - 21'(dby5);
    m_arg     = 11'(yday6) + 11'd31;
    m_arg5    = {m_arg[8:0], 2'b00} + m_arg;
    mp        = 23'(m_arg5) * 23'(RECIP_153);
    mday      = yday7 - days_before_month(mon7) + 9'd1;
    late      = yday7 >= FIRST_JAN_YDAY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[DATE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d1    <= d_shift;
    py1   <= 36'(d_shift + 20'd2) * 36'(RECIP_YEAR);
    dw1   <= dw_next;
    pw1   <= 33'(dw_next) * 33'(RECIP_7);

    d2    <= d1;
    y2    <= y_est;
    r2    <= r_full[18:0];
    wd2   <= wd_full[2:0];

    d3    <= d2;
    y3    <= (r2 >= 19'(DAYS_PER_400Y)) ? y2 + 12'd1 : y2;
    wd3   <= wd2;

    d4    <= d3;
    y4    <= y3;
    q4    <= p100[23:19];
    wd4   <= wd3;

    d5    <= d4;
    y5    <= y4;
    dby5  <= dby_next;
    leap5 <= leap_next;
    wd5   <= wd4;

    // negative day of year falls back into the previous year
    if (yd_diff[20]) begin
      yday6 <= yd_diff[8:0] + DAYS_PER_YEAR + 9'(leap5);
      y6    <= y5 - 12'd1;
    end else begin
      yday6 <= yd_diff[8:0];
      y6    <= y5;
    end
    wd6   <= wd5;

    yday7 <= yday6;
    y7    <= y6;
    mon7  <= mp[22:19];
    wd7   <= wd6;

    // january and february belong to the next calendar year
    date.year         <= late ? y7 + 12'd1 : y7;
    date.month        <= late ? mon7 - 4'd10 : mon7 + 4'd2;
    date.day_of_month <= mday[4:0];
    date.weekday      <= wd7;
  end

  assign out_valid = valid[DATE_LAT-1];

  a_yday_range: assert property (@(posedge clk) disable iff (rst)
    valid[5] |-> yday6 <= DAYS_PER_YEAR)
    else $error("day of year out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> date.weekday <= 3'd6)
    else $error("weekday out of range");

  a_feb_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && date.month == 4'd2) |-> date.day_of_month <= 5'd29)
    else $error("february day out of range");

endmodule

>>> sv/epoch_seconds_to_utc_calendar.sv
// epoch_seconds_to_utc_calendar: top level, splits seconds into days and
// seconds of day, then runs date and time-of-day pipelines side by side
// depends on estc_pkg, estc_time_of_day, estc_civil_date
//
//   channel   handshake      payload
//   input     start / busy   epoch_seconds
//   result    done strobe    second, minute, hour, day_of_month, month,
//                            year, weekday
//
// one transfer per cycle, every cycle while rst is low
// done follows start through the day split (3 stages) and the date path (8 stages)
// busy follows rst and is low otherwise
// synchronous reset clears all valid bits; items in flight are dropped
// results leave on done for one cycle; nothing stalls the pipeline
module epoch_seconds_to_utc_calendar
  import estc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  output logic        busy,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [11:0] year,
  output logic [2:0]  weekday
);

  localparam int unsigned TodPad = DATE_LAT - TOD_LAT;

  logic        v1;
  logic        v2;
  logic        v3;
  logic [31:0] secs1;
  logic [50:0] prod1;
  logic [15:0] days2;
  logic [17:0] rem2;
  logic [15:0] days3;
  logic [16:0] rem3;

  logic [15:0] q_est;
  logic [32:0] q_secs;
  logic [32:0] rem_full;
  logic        rem_over;

  tod_t        tod_raw;
  tod_t        tod_dly [TodPad];
  cal_date_t   date_out;

  assign busy = rst;

  always_comb begin
    q_est    = prod1[50:35];
    q_secs   = 33'(q_est) * 33'(SECS_PER_DAY);
    rem_full = 33'(secs1) - q_secs;
    rem_over = rem2 >= 18'(SECS_PER_DAY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    secs1 <= epoch_seconds;
    prod1 <= 51'(epoch_seconds[31:7]) * 51'(RECIP_DAY);
    days2 <= q_est;
    rem2  <= rem_full[17:0];
    if (rem_over) begin
      days3 <= days2 + 16'd1;
      rem3  <= 17'(rem2 - 18'(SECS_PER_DAY));
    end else begin
      days3 <= days2;
      rem3  <= rem2[16:0];
    end
  end

  estc_civil_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .days      (days3),
    .out_valid (done),
    .date      (date_out)
  );

  estc_time_of_day u_tod (
    .clk         (clk),
    .secs_of_day (rem3),
    .tod         (tod_raw)
  );

  // align time of day with the deeper date path
  always_ff @(posedge clk) begin
    tod_dly[0] <= tod_raw;
    for (int i = 1; i < TodPad; i++) begin
      tod_dly[i] <= tod_dly[i-1];
    end
  end

  assign second       = tod_dly[TodPad-1].second;
  assign minute       = tod_dly[TodPad-1].minute;
  assign hour         = tod_dly[TodPad-1].hour;
  assign day_of_month = date_out.day_of_month;
  assign month        = date_out.month;
  assign year         = date_out.year;
  assign weekday      = date_out.weekday;

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching transfer");

  a_transfer_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("transfer produced no result");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1))
    else $error("month or day out of range");

endmodule

>>> tb/epoch_seconds_to_utc_calendar_tb.sv
// epoch_seconds_to_utc_calendar_tb: self-checking bench for the epoch seconds
// to utc calendar converter, with random start gaps and a calendar predictor
// depends on estc_pkg and epoch_seconds_to_utc_calendar
module epoch_seconds_to_utc_calendar_tb;
  import estc_pkg::*;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
  } utc_fields_t;

  class calendar_scoreboard;
    utc_fields_t pending[$];
    int unsigned mismatches;

    function utc_fields_t civil_time_of(logic [31:0] secs);
      longint unsigned n, days, rem, yr, mon, mday, wday, hr, mi, se;
      longint yday;
      utc_fields_t r;
      n = secs;
      days = n / 86400;
      wday = (4 + days) % 7;
      rem = n % 86400;
      hr = rem / 3600;
      rem = rem % 3600;
      mi = rem / 60;
      se = rem % 60;
      // count days from march 1 of year 0
      days = days - 59 + 719527;
      yr = (days + 2) * 400 / 146097;
      yday = longint'(days) - longint'(365 * yr + yr / 4 - yr / 100 + yr / 400);
      if (yday < 0) begin
        yday += ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 366 : 365;
        yr--;
      end
      mon = (longint'(yday) + 31) * 10 / 306;
      mday = longint'(yday) - (367 * mon / 12 - 30) + 1;
      if (yday >= 306) begin
        yr++;
        mon -= 10;
      end else begin
        mon += 2;
      end
      r.second = se[5:0];
      r.minute = mi[5:0];
      r.hour = hr[4:0];
      r.day_of_month = mday[4:0];
      r.month = mon[3:0];
      r.year = yr[11:0];
      r.weekday = wday[2:0];
      return r;
    endfunction

    function void note(logic [31:0] secs);
      pending.push_back(civil_time_of(secs));
    endfunction

    function void check(utc_fields_t got);
      utc_fields_t want;
      if (pending.size() == 0) begin
        $error("result with no transfer pending: %p", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.second !== want.second) begin
        $error("second: expected %0d, got %0d", want.second, got.second);
        mismatches++;
      end
      if (got.minute !== want.minute) begin
        $error("minute: expected %0d, got %0d", want.minute, got.minute);
        mismatches++;
      end
      if (got.hour !== want.hour) begin
        $error("hour: expected %0d, got %0d", want.hour, got.hour);
        mismatches++;
      end
      if (got.day_of_month !== want.day_of_month) begin
        $error("day_of_month: expected %0d, got %0d", want.day_of_month, got.day_of_month);
        mismatches++;
      end
      if (got.month !== want.month) begin
        $error("month: expected %0d, got %0d", want.month, got.month);
        mismatches++;
      end
      if (got.year !== want.year) begin
        $error("year: expected %0d, got %0d", want.year, got.year);
        mismatches++;
      end
      if (got.weekday !== want.weekday) begin
        $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] epoch_seconds;
  logic        busy;
  logic        done;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [11:0] year;
  logic [2:0]  weekday;
  logic        took_item;

  calendar_scoreboard sb = new();

  epoch_seconds_to_utc_calendar dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .epoch_seconds(epoch_seconds),
    .busy(busy),
    .done(done),
    .second(second),
    .minute(minute),
    .hour(hour),
    .day_of_month(day_of_month),
    .month(month),
    .year(year),
    .weekday(weekday)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    took_item <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy)
        sb.note(epoch_seconds);
      if (done === 1'b1)
        sb.check(utc_fields_t'{second, minute, hour, day_of_month, month, year, weekday});
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_seconds(input logic [31:0] secs);
    start <= 1'b1;
    epoch_seconds <= secs;
    do @(negedge clk); while (!took_item);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    epoch_seconds <= $urandom;
    @(negedge clk);
  endtask

  // days from 1970-01-01 to january 1 of year y
  function automatic longint unsigned days_to_jan1(int unsigned y);
    return 365 * (y - 1970) + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
  endfunction

  function automatic logic [31:0] random_seconds();
    longint unsigned day, sod, total;
    int unsigned pick;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0: sod = 0;
      1: sod = 86399;
      default: sod = $urandom_range(86399);
    endcase
    if (pick < 35) begin
      return $urandom;
    end else if (pick < 60) begin
      // late february and early march
      day = days_to_jan1($urandom_range(2105, 1970)) + $urandom_range(61, 55);
    end else if (pick < 80) begin
      day = days_to_jan1($urandom_range(2106, 1971)) - 1 + $urandom_range(1);
    end else begin
      day = $urandom_range(49710);
    end
    total = day * 86400 + sod;
    if (total > 64'hFFFF_FFFF)
      total = 64'hFFFF_FFFF - $urandom_range(86399);
    return total[31:0];
  endfunction

  logic [31:0] directed_secs[] = '{
    32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000,
    32'd68169600, 32'd68255999, 32'd68256000,
    32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
    32'd4107456000, 32'd4107542400, 32'd4233686400,
    32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd4291747199, 32'd4294944000, 32'hFFFF_FFFF
  };

  initial begin
    int unsigned i;
    rst = 1'b1;
    start = 1'b0;
    epoch_seconds = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_secs[k]) begin
      send_seconds(directed_secs[k]);
    end
    for (i = 0; i < 1950; i++) begin
      if (i == 400) begin
        start <= 1'b0;
        do @(negedge clk); while (sb.pending.size() != 0);
      end
      if (i < 800 || i >= 1100) begin
        while ($urandom_range(99) < 26)
          hold_off();
      end
      send_seconds(random_seconds());
    end
    start <= 1'b0;
    while (sb.pending.size() != 0)
      @(negedge clk);
    repeat (TOTAL_LAT + 5) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
